### src/wua_pkg.sv
// Shared types and constants for the windowed usage averager.
`default_nettype none
package wua_pkg;

	localparam int DATA_W     = 16;
	localparam int WINDOW_DEF = 60;

	// one ring entry: the three averaged channels
	typedef struct packed {
		logic [DATA_W-1:0] msg_v;
		logic [DATA_W-1:0] buf_v;
		logic [DATA_W-1:0] mem_v;
	} chan_t;

	// ring access control from the pipeline
	typedef struct packed {
		logic rd_en;   // request accepted: read the slot it overwrites
		logic wr_en;   // stage 1 retires: write its values back
	} ring_ctrl_t;

endpackage
`default_nettype wire

### src/wua_ring.sv
// Sample ring: slot pointer, fill flag and one-read one-write memory.
`default_nettype none
module wua_ring #(
	parameter int WINDOW = wua_pkg::WINDOW_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wua_pkg::ring_ctrl_t     ctrl,
	input  wua_pkg::chan_t          new_val,
	output wua_pkg::chan_t          new_s1,
	output wua_pkg::chan_t          old_s1
);
	import wua_pkg::*;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] addr_s1;
	logic              full_q;
	logic              hit_s1;
	chan_t             rd_s1;
	chan_t             mem_q [WINDOW];

	// slots fill in order, so a slot holds data once the ring has wrapped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			full_q <= 1'b0;
			hit_s1 <= 1'b0;
		end else if (ctrl.rd_en) begin
			hit_s1 <= full_q;
			if (slot_q == LAST_SLOT) begin
				slot_q <= '0;
				full_q <= 1'b1;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_s1   <= mem_q[slot_q];
			addr_s1 <= slot_q;
			new_s1  <= new_val;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[addr_s1] <= new_s1;
		end
	end

	assign old_s1 = hit_s1 ? rd_s1 : '0;

endmodule
`default_nettype wire

### src/wua_sum.sv
// Running window sums: subtract the overwritten sample, add the new one.
`default_nettype none
module wua_sum #(
	parameter int WINDOW = wua_pkg::WINDOW_DEF
) (
	input  wire                                                clk,
	input  wire                                                arst_n,
	input  wire                                                en,
	input  wua_pkg::chan_t                                     new_val,
	input  wua_pkg::chan_t                                     old_val,
	output logic [wua_pkg::DATA_W+$clog2(WINDOW)-1:0]          mem_sum_q,
	output logic [wua_pkg::DATA_W+$clog2(WINDOW)-1:0]          buf_sum_q,
	output logic [wua_pkg::DATA_W+$clog2(WINDOW)-1:0]          msg_sum_q
);
	import wua_pkg::*;

	localparam int SUM_W = DATA_W + $clog2(WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_sum_q <= '0;
			buf_sum_q <= '0;
			msg_sum_q <= '0;
		end else if (en) begin
			mem_sum_q <= mem_sum_q - SUM_W'(old_val.mem_v) + SUM_W'(new_val.mem_v);
			buf_sum_q <= buf_sum_q - SUM_W'(old_val.buf_v) + SUM_W'(new_val.buf_v);
			msg_sum_q <= msg_sum_q - SUM_W'(old_val.msg_v) + SUM_W'(new_val.msg_v);
		end
	end

endmodule
`default_nettype wire

### src/wua_scale.sv
// Floor division of a window sum by WINDOW through an exact reciprocal multiply.
`default_nettype none
module wua_scale #(
	parameter int WINDOW = wua_pkg::WINDOW_DEF
) (
	input  wire                                          clk,
	input  wire                                          en,
	input  wire [wua_pkg::DATA_W+$clog2(WINDOW)-1:0]     sum,
	output logic [wua_pkg::DATA_W-1:0]                   quo_q
);
	import wua_pkg::*;

	localparam int SUM_W  = DATA_W + $clog2(WINDOW);
	localparam int SHIFT  = SUM_W + $clog2(WINDOW);
	localparam int PROD_W = 2 * SUM_W + 1;
	// ceil(2^SHIFT / WINDOW), fits in SUM_W+1 bits, exact for any SUM_W-bit sum
	localparam logic [63:0] MAGIC = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(sum) * PROD_W'(MAGIC[SUM_W:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= prod[SHIFT +: DATA_W];
		end
	end

endmodule
`default_nettype wire

### src/windowed_usage_averager_unit.sv
// Top level: boxcar moving average of pool, buffer and message usage.
// Pipeline: ring read, window sums, scaled output register; an output stall holds all.
// Throughput: one request per cycle unless the output stalls; the ring memory is
//   read at accept and written back as stage 1 retires, so adjacent requests never touch one slot.
// Reset: async, active low; clears sums, slot pointer, fill flag, total_blocks.
//   Ring slots read as zero until the first lap completes; no clearing pass.
`default_nettype none
module windowed_usage_averager_unit #(
	parameter int WINDOW = wua_pkg::WINDOW_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// config: total_blocks
	input  wire                            cfg_wr_en,
	input  wire [wua_pkg::DATA_W-1:0]      cfg_wr_data,
	// request stream
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	// [15:0] free_blocks, [31:16] buffer_usage, [47:32] message_count,
	// [63:48] error_count
	input  wire [4*wua_pkg::DATA_W-1:0]    s_axis_tdata,
	// result stream
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	// [15:0] mem_avg, [31:16] buf_avg, [47:32] msg_avg,
	// [63:48] newest_err
	output logic [4*wua_pkg::DATA_W-1:0]   m_axis_tdata
);
	import wua_pkg::*;

	localparam int SUM_W = DATA_W + $clog2(WINDOW);

	logic [DATA_W-1:0] total_blocks_q;

	logic              adv;       // whole pipeline moves this cycle
	logic              accept;
	logic              retire_s1;
	logic              vld_s1;
	logic              vld_s2;
	logic              out_vld_q;

	logic [DATA_W-1:0] free_blocks;
	logic [DATA_W-1:0] used_blocks;
	logic [DATA_W-1:0] err_s1;
	logic [DATA_W-1:0] err_s2;
	logic [DATA_W-1:0] err_q;

	chan_t             new_val;
	chan_t             new_s1;
	chan_t             old_s1;
	ring_ctrl_t        ring_ctrl;

	logic [SUM_W-1:0]  mem_sum;
	logic [SUM_W-1:0]  buf_sum;
	logic [SUM_W-1:0]  msg_sum;
	logic [DATA_W-1:0] avg_mem_q;
	logic [DATA_W-1:0] avg_buf_q;
	logic [DATA_W-1:0] msg_avg_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_blocks_q <= '0;
		end else if (cfg_wr_en) begin
			total_blocks_q <= cfg_wr_data;
		end
	end

	// single stall point: everything holds only while a result waits
	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;
	assign retire_s1     = adv && vld_s1;

	// used = total - free, floored at zero
	assign free_blocks = s_axis_tdata[DATA_W-1:0];
	assign used_blocks = (total_blocks_q > free_blocks) ? (total_blocks_q - free_blocks) : '0;

	assign new_val.mem_v = used_blocks;
	assign new_val.buf_v = s_axis_tdata[2*DATA_W-1:DATA_W];
	assign new_val.msg_v = s_axis_tdata[3*DATA_W-1:2*DATA_W];

	assign ring_ctrl.rd_en = accept;
	assign ring_ctrl.wr_en = retire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
		end
	end

	// error count rides alongside the sums
	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1 <= s_axis_tdata[4*DATA_W-1:3*DATA_W];
		end
		if (retire_s1) begin
			err_s2 <= err_s1;
		end
		if (adv && vld_s2) begin
			err_q <= err_s2;
		end
	end

	wua_ring #(.WINDOW(WINDOW)) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ring_ctrl),
		.new_val (new_val),
		.new_s1  (new_s1),
		.old_s1  (old_s1)
	);

	wua_sum #(.WINDOW(WINDOW)) u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (retire_s1),
		.new_val   (new_s1),
		.old_val   (old_s1),
		.mem_sum_q (mem_sum),
		.buf_sum_q (buf_sum),
		.msg_sum_q (msg_sum)
	);

	wua_scale #(.WINDOW(WINDOW)) u_scale_mem (
		.clk   (clk),
		.en    (adv && vld_s2),
		.sum   (mem_sum),
		.quo_q (avg_mem_q)
	);

	wua_scale #(.WINDOW(WINDOW)) u_scale_buf (
		.clk   (clk),
		.en    (adv && vld_s2),
		.sum   (buf_sum),
		.quo_q (avg_buf_q)
	);

	wua_scale #(.WINDOW(WINDOW)) u_scale_msg (
		.clk   (clk),
		.en    (adv && vld_s2),
		.sum   (msg_sum),
		.quo_q (msg_avg_q)
	);

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {err_q, msg_avg_q, avg_buf_q, avg_mem_q};

endmodule
`default_nettype wire

### src/wua_checker.sv
// Port-level checks for the averager, bound to the top level.
`default_nettype none
module wua_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [63:0] m_axis_tdata
);

	// result held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	// input only blocks behind a waiting result
	a_no_idle_block: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input blocked with no pending result");

	// unstalled request shows its result after the ring, sum and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
			##1 m_axis_tready |=> m_axis_tvalid)
		else $error("result missing after unstalled latency");

endmodule

bind windowed_usage_averager_unit wua_checker u_wua_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
